FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define PFX_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfx assertion failed");

// consequent holds in the cycle after the antecedent
`define PFX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfx assertion failed");

`endif

FILE: rtl/core/pfx_pkg.sv
// shared types, codes and widths of the postfix evaluator
// no dependencies
package pfx_pkg;

	localparam int WORD_W      = 32;
	localparam int SYM_W       = 8;
	localparam int STATUS_W    = 2;
	localparam int STACK_DEPTH = 5;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ITER_W      = $clog2(WORD_W);

	// ascii codes
	localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CH_TIMES = 8'h2A;
	localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

	// alu operations
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ERR_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ERR_UNDERFLOW = 2'd2;
	localparam logic [STATUS_W-1:0] ERR_DIVZERO   = 2'd3;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} pfx_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		logic [STATUS_W-1:0]      status;
	} pfx_result_t;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} pfx_alu_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] result;
	} pfx_alu_rsp_t;

endpackage

FILE: rtl/core/pfx_alu.sv
// bit-serial arithmetic unit: add, subtract, multiply, signed divide
// depends on pfx_pkg
module pfx_alu import pfx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  pfx_alu_req_t      req,
	input  logic [WORD_W-1:0] lhs,
	input  logic [WORD_W-1:0] rhs,
	output pfx_alu_rsp_t      rsp
);

	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_ITER = 2'd1;
	localparam logic [1:0] A_FIX  = 2'd2;

	logic [1:0]        state_q;
	logic [ITER_W-1:0] cnt_q;
	logic [1:0]        op_q;
	logic [WORD_W-1:0] a_q, b_q, r_q;
	logic              carry_q, neg_q;

	logic [WORD_W:0]   rem_ext, diff;
	logic              ge;
	logic              sum_bit, carry_d;

	// restoring divide step
	assign rem_ext = {r_q, a_q[WORD_W-1]};
	assign diff    = rem_ext - {1'b0, b_q};
	assign ge      = ~diff[WORD_W];

	// serial full adder
	assign sum_bit = a_q[0] ^ b_q[0] ^ carry_q;
	assign carry_d = (a_q[0] & b_q[0]) | (carry_q & (a_q[0] ^ b_q[0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						state_q <= A_ITER;
						cnt_q   <= '0;
					end
				end
				A_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ITER_W'(WORD_W - 1)) state_q <= A_FIX;
				end
				A_FIX: state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == A_IDLE && req.start) begin
			op_q    <= req.op;
			r_q     <= '0;
			carry_q <= (req.op == OP_SUB);
			neg_q   <= lhs[WORD_W-1] ^ rhs[WORD_W-1];
			case (req.op)
				OP_SUB: begin
					a_q <= lhs;
					b_q <= ~rhs;
				end
				OP_DIV: begin
					a_q <= lhs[WORD_W-1] ? -lhs : lhs;
					b_q <= rhs[WORD_W-1] ? -rhs : rhs;
				end
				default: begin
					a_q <= lhs;
					b_q <= rhs;
				end
			endcase
		end else if (state_q == A_ITER) begin
			case (op_q)
				OP_MUL: begin
					r_q <= {r_q[WORD_W-2:0], 1'b0} + (a_q[WORD_W-1] ? b_q : '0);
					a_q <= {a_q[WORD_W-2:0], 1'b0};
				end
				OP_DIV: begin
					r_q <= ge ? diff[WORD_W-1:0] : rem_ext[WORD_W-1:0];
					a_q <= {a_q[WORD_W-2:0], ge};
				end
				default: begin
					// add and subtract, lsb first
					r_q     <= {sum_bit, r_q[WORD_W-1:1]};
					a_q     <= {1'b0, a_q[WORD_W-1:1]};
					b_q     <= {1'b0, b_q[WORD_W-1:1]};
					carry_q <= carry_d;
				end
			endcase
		end
	end

	always_comb begin
		rsp.done   = (state_q == A_FIX);
		rsp.result = r_q;
		if (op_q == OP_DIV) rsp.result = neg_q ? -a_q : a_q;
	end

endmodule

FILE: rtl/core/postfix_expression_evaluator.sv
// top level of the postfix expression evaluator: operand stack, control, result register
// depends on pfx_pkg and pfx_alu
//
// usage
// - item channel (item_valid, item_stall, item): one ascii character per transaction,
//   item.last marks the final character of an expression
// - result channel (result_valid, result_stall, result): one transaction per
//   expression, carrying the final value and the first error seen
// - a digit, a character that is neither digit nor operator, and a divide by zero do
//   not use the alu; plus, minus, times and divide stall the item channel while the
//   bit-serial alu works, one bit per cycle over 32 bits
// - the last transaction of an expression is followed by the final pop;
//   the result shows up on the cycle after that
// - item_stall is high while an operation runs in the alu and during the final pop,
//   including while it waits for a free result register
// - the result register lets a new expression start while the previous result
//   is still stalled by the receiver; only a second final pop waits for it
// - reset empties the stack, clears the error and drops any pending result
module postfix_expression_evaluator import pfx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  pfx_item_t   item,
	output logic        result_valid,
	input  logic        result_stall,
	output pfx_result_t result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	// control state
	logic [1:0]          state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [STATUS_W-1:0] err_q, err_d;
	logic                last_q, last_d;
	logic                result_valid_q;
	pfx_result_t         result_q;

	// stack: entry 0 is the top, entries at or above count_q hold garbage
	logic [WORD_W-1:0]   stack_q [STACK_DEPTH];
	logic [WORD_W-1:0]   stack_d [STACK_DEPTH];

	logic                take, emit;
	logic                is_digit, is_arith;
	logic [1:0]          op;
	logic [WORD_W-1:0]   lhs, rhs, push_val;
	logic                shift_up2, shift_up1, push_down;
	logic                has_two;

	pfx_alu_req_t        alu_req;
	pfx_alu_rsp_t        alu_rsp;

	assign take       = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);

	// character decode
	always_comb begin
		is_digit = (item.symbol inside {[CH_ZERO:CH_NINE]});
		is_arith = 1'b1;
		op       = OP_ADD;
		case (item.symbol)
			CH_PLUS:  op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_TIMES: op = OP_MUL;
			CH_SLASH: op = OP_DIV;
			default:  is_arith = 1'b0;
		endcase
	end

	// operands, an empty slot pops as zero
	assign has_two = (count_q >= CNT_W'(2));
	assign rhs     = (count_q != '0) ? stack_q[0] : '0;
	assign lhs     = has_two ? stack_q[1] : '0;

	// main control
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		err_d     = err_q;
		last_d    = last_q;
		shift_up2 = 1'b0;
		shift_up1 = 1'b0;
		push_down = 1'b0;
		push_val  = '0;
		emit      = 1'b0;
		alu_req   = '{start: 1'b0, op: op};
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					last_d = item.last;
					if (is_digit) begin
						push_val = WORD_W'(item.symbol - CH_ZERO);
						if (count_q < CNT_W'(STACK_DEPTH)) begin
							push_down = 1'b1;
							count_d   = count_q + 1'b1;
						end else if (err_q == ERR_OK) begin
							err_d = ERR_OVERFLOW;
						end
						state_d = item.last ? ST_EMIT : ST_IDLE;
					end else begin
						// two pops, rhs first
						count_d = has_two ? count_q - CNT_W'(2) : '0;
						if (!has_two && err_q == ERR_OK) err_d = ERR_UNDERFLOW;
						if (is_arith && op == OP_DIV && rhs == '0) begin
							// divide by zero pushes zero right away
							shift_up1 = 1'b1;
							count_d   = count_d + 1'b1;
							if (err_d == ERR_OK) err_d = ERR_DIVZERO;
							state_d = item.last ? ST_EMIT : ST_IDLE;
						end else if (is_arith) begin
							shift_up2     = 1'b1;
							alu_req.start = 1'b1;
							state_d       = ST_CALC;
						end else begin
							// unknown character: operands are dropped
							shift_up2 = 1'b1;
							state_d   = item.last ? ST_EMIT : ST_IDLE;
						end
					end
				end
			end
			ST_CALC: begin
				if (alu_rsp.done) begin
					// two entries were just popped, so there is always room
					push_down = 1'b1;
					push_val  = alu_rsp.result;
					count_d   = count_q + 1'b1;
					state_d   = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (!result_valid_q || !result_stall) begin
					emit    = 1'b1;
					count_d = '0;
					err_d   = ERR_OK;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// stack moves: pop two, pop two and push one, or push one
	always_comb begin
		stack_d = stack_q;
		if (shift_up2) begin
			for (int i = 0; i < STACK_DEPTH - 2; i++) stack_d[i] = stack_q[i + 2];
		end else if (shift_up1) begin
			for (int i = 1; i < STACK_DEPTH - 1; i++) stack_d[i] = stack_q[i + 1];
			stack_d[0] = push_val;
		end else if (push_down) begin
			for (int i = 1; i < STACK_DEPTH; i++) stack_d[i] = stack_q[i - 1];
			stack_d[0] = push_val;
		end
	end

	always_ff @(posedge clk) begin
		stack_q <= stack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			err_q          <= ERR_OK;
			last_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			err_q   <= err_d;
			last_q  <= last_d;
			if (emit) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	// final pop; an empty stack gives zero and, if no earlier error, underflow
	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.value  <= (count_q != '0) ? stack_q[0] : '0;
			result_q.status <= (count_q == '0 && err_q == ERR_OK) ? ERR_UNDERFLOW : err_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	pfx_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.lhs    (lhs),
		.rhs    (rhs),
		.rsp    (alu_rsp)
	);

endmodule

FILE: rtl/core/pfx_checker.sv
// port-level checker for the postfix evaluator, bound to the top level
// depends on pfx_pkg and assert_macros.svh
`include "assert_macros.svh"

module pfx_checker import pfx_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input pfx_item_t   item,
	input logic        result_valid,
	input logic        result_stall,
	input pfx_result_t result
);

	logic item_take, take_digit, take_serial_op;

	assign item_take  = item_valid && !item_stall;
	assign take_digit = item_take && item.symbol >= CH_ZERO && item.symbol <= CH_NINE;
	assign take_serial_op = item_take &&
		(item.symbol == CH_PLUS || item.symbol == CH_MINUS || item.symbol == CH_TIMES);

	// a stalled result holds
	`PFX_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
	// a digit in the middle of an expression does not stall the next item
	`PFX_ASSERT_NEXT(a_digit_fast, take_digit && !item.last, !item_stall)
	// add, subtract and multiply go through the serial unit
	`PFX_ASSERT_NEXT(a_op_busy, take_serial_op, item_stall)
	// only a final character can raise a result
	`PFX_ASSERT_NEXT(a_no_early_result, item_take && !item.last && !result_valid, !result_valid)
	// a result is never dropped while stalled
	`PFX_ASSERT_SAME(a_drop_only_taken, $fell(result_valid), $past(!result_stall))

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (.*);
